// ----- design/scqe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scqe_pkg: shared types and constants
// Command codes, item modes, driver status codes and controller commands.
// ----------------------------------------------------------------------------
package scqe_pkg;

    // item modes
    localparam logic [1:0] MODE_ENQ   = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // command codes
    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_PLAY    = 4'd1;
    localparam logic [3:0] CMD_STOP    = 4'd2;
    localparam logic [3:0] CMD_PAUSE   = 4'd3;
    localparam logic [3:0] CMD_RESUME  = 4'd4;
    localparam logic [3:0] CMD_TRKVOL  = 4'd5;
    localparam logic [3:0] CMD_FADE    = 4'd6;
    localparam logic [3:0] CMD_SFXPLAY = 4'd7;
    localparam logic [3:0] CMD_SFXSTOP = 4'd8;
    localparam logic [3:0] CMD_MASTER  = 4'd9;
    localparam logic [3:0] CMD_RESET   = 4'd10;

    // driver status codes
    localparam logic [2:0] ST_STOPPED = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_PLAYING = 3'd2;
    localparam logic [2:0] ST_PAUSED  = 3'd3;

    localparam logic [6:0] VOL_CAP = 7'd127;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the input item
        logic ring_rd;  // read the ring head
        logic exec;     // apply the item and present the result
        logic clear;    // step the slot clearing sweep
    } scqe_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic clear_req;  // driver reset executed, sweep the slots again
    } scqe_sts_t;

endpackage
`default_nettype wire

// ----- design/scqe_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scqe_ctrl: item sequencer
// Clears the slot table after reset and after a driver reset command,
// then runs each item through load, ring read and execute.
// ----------------------------------------------------------------------------
module scqe_ctrl
    import scqe_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    output scqe_ctl_t  ctl,
    input  scqe_sts_t  sts
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (sts.clear_done) state_next = S_IDLE;
            S_IDLE:  if (start) state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = sts.clear_req ? S_CLEAR : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign ctl.load    = (state_reg == S_IDLE) && start;
    assign ctl.ring_rd = (state_reg == S_READ);
    assign ctl.exec    = (state_reg == S_EXEC);
    assign ctl.clear   = (state_reg == S_CLEAR);

endmodule
`default_nettype wire

// ----- design/scqe_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scqe_dp: queue, driver registers and slot table
// Ring memory, pointers, driver state, slot memory with registered enable
// bits and the result registers.
// ----------------------------------------------------------------------------
module scqe_dp
    import scqe_pkg::*;
#(
    parameter int QUEUE_DEPTH       = 16,
    parameter int SLOT_COUNT        = 32,
    parameter int EFFECT_FIRST_SLOT = 16
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  scqe_ctl_t   ctl,
    output scqe_sts_t   sts,
    input  wire  [1:0]  mode,
    input  wire  [3:0]  cmd_code,
    input  wire  [15:0] track_id,
    input  wire  [7:0]  volume,
    input  wire  [7:0]  pan,
    input  wire  [5:0]  slot_index,
    input  wire         slot_enable,
    output logic        done,
    output logic        accepted,
    output logic [2:0]  driver_status,
    output logic [6:0]  master_level,
    output logic [15:0] current_track,
    output logic [4:0]  queue_count,
    output logic        slot_enabled,
    output logic [7:0]  slot_volume,
    output logic [7:0]  slot_pan
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(SLOT_COUNT);

    // captured item
    logic [1:0]  mode_reg;
    logic [3:0]  type_reg;
    logic [15:0] target_reg;
    logic [7:0]  vol_reg, pan_reg;
    logic [5:0]  idx_reg;
    logic        en_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mode_reg   <= mode;
            type_reg   <= cmd_code;
            target_reg <= track_id;
            vol_reg    <= volume;
            pan_reg    <= pan;
            idx_reg    <= slot_index;
            en_reg     <= slot_enable;
        end
    end

    // command ring memory
    logic [35:0] ring_mem [QUEUE_DEPTH];
    logic [35:0] head_reg;
    logic [QW-1:0] rp_reg, wp_reg;
    logic [CW-1:0] cnt_reg;

    // slot memory holds volume and pan; enables are flip-flops
    logic [15:0] slot_mem [SLOT_COUNT];
    logic [15:0] slot_rd_reg;
    logic [SLOT_COUNT-1:0] en_bits_reg;
    logic [SW-1:0] clr_reg;

    logic idx_ok;
    assign idx_ok = ({26'd0, idx_reg} < 32'(SLOT_COUNT));

    // first free effect slot
    logic          free_found;
    logic [SW-1:0] free_idx;
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (i >= EFFECT_FIRST_SLOT && !en_bits_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    logic [SLOT_COUNT-1:0] fx_mask;
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
            fx_mask[i] = (i >= EFFECT_FIRST_SLOT);
    end

    // head entry fields
    logic [3:0]  h_type;
    logic [15:0] h_target;
    logic [7:0]  h_vol, h_pan;
    assign {h_type, h_target, h_vol, h_pan} = head_reg;
    logic [6:0] h_vol_cap;
    assign h_vol_cap = (h_vol > {1'b0, VOL_CAP}) ? VOL_CAP : h_vol[6:0];

    logic do_enq, do_exec, do_write;
    assign do_enq   = ctl.exec && mode_reg == MODE_ENQ && cnt_reg < CW'(QUEUE_DEPTH);
    assign do_exec  = ctl.exec && mode_reg == MODE_EXEC && cnt_reg != '0;
    assign do_write = ctl.exec && mode_reg == MODE_WRITE && idx_ok;

    logic fx_play, fx_stop, drv_reset;
    assign fx_play   = do_exec && h_type == CMD_SFXPLAY && free_found;
    assign fx_stop   = do_exec && h_type == CMD_SFXSTOP;
    assign drv_reset = do_exec && h_type == CMD_RESET;

    assign sts.clear_done = ctl.clear && (clr_reg == SW'(SLOT_COUNT - 1));
    assign sts.clear_req  = drv_reset;

    // ring and slot memories
    always_ff @(posedge clk)
    begin
        if (do_enq)
            ring_mem[wp_reg] <= {type_reg, target_reg, vol_reg, pan_reg};
        if (ctl.ring_rd)
            head_reg <= ring_mem[rp_reg];
        if (ctl.load)
            slot_rd_reg <= slot_mem[slot_index[SW-1:0]];
        if (ctl.clear)
            slot_mem[clr_reg] <= '0;
        else if (do_write)
            slot_mem[idx_reg[SW-1:0]] <= {vol_reg, pan_reg};
        else if (fx_play)
            slot_mem[free_idx] <= {1'b0, h_vol_cap, h_pan};
    end

    // driver and queue state
    logic [2:0]  st_reg;
    logic [6:0]  mst_reg;
    logic [15:0] trk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg      <= '0;
            wp_reg      <= '0;
            cnt_reg     <= '0;
            st_reg      <= ST_READY;
            mst_reg     <= VOL_CAP;
            trk_reg     <= '0;
            en_bits_reg <= '0;
            clr_reg     <= '0;
            done        <= 1'b0;
        end
        else
        begin
            done <= ctl.exec;
            if (ctl.clear)
                clr_reg <= clr_reg + SW'(1);
            if (do_enq)
            begin
                wp_reg  <= (wp_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + QW'(1);
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (do_write)
                en_bits_reg[idx_reg[SW-1:0]] <= en_reg;
            if (do_exec)
            begin
                // driver reset empties the queue and restarts the slot sweep
                if (drv_reset)
                begin
                    rp_reg      <= '0;
                    wp_reg      <= '0;
                    cnt_reg     <= '0;
                    st_reg      <= ST_READY;
                    mst_reg     <= VOL_CAP;
                    trk_reg     <= '0;
                    en_bits_reg <= '0;
                    clr_reg     <= '0;
                end
                else
                begin
                    rp_reg  <= (rp_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + QW'(1);
                    cnt_reg <= cnt_reg - CW'(1);
                    case (h_type)
                        CMD_PLAY:
                        begin
                            trk_reg <= h_target;
                            st_reg  <= ST_PLAYING;
                        end
                        CMD_STOP:
                        begin
                            trk_reg <= '0;
                            st_reg  <= ST_STOPPED;
                        end
                        CMD_PAUSE:  st_reg <= ST_PAUSED;
                        CMD_RESUME: if (trk_reg != '0) st_reg <= ST_PLAYING;
                        CMD_MASTER: mst_reg <= h_vol_cap;
                        CMD_SFXPLAY: if (free_found) en_bits_reg[free_idx] <= 1'b1;
                        CMD_SFXSTOP: en_bits_reg <= en_bits_reg & ~fx_mask;
                        default: ;
                    endcase
                end
            end
        end
    end

    // result fields, valid while done is high
    logic rd_hit;
    logic rd_hit_reg, en_rd_reg;
    assign rd_hit = (mode_reg == MODE_READ) && idx_ok;

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
            accepted <= do_enq || do_exec;
    end

    assign driver_status = st_reg;
    assign master_level  = mst_reg;
    assign current_track = trk_reg;
    assign queue_count   = 5'(cnt_reg);
    assign slot_enabled  = rd_hit_reg & en_rd_reg;
    assign slot_volume   = rd_hit_reg ? slot_rd_reg[15:8] : 8'd0;
    assign slot_pan      = rd_hit_reg ? slot_rd_reg[7:0] : 8'd0;

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            rd_hit_reg <= rd_hit;
            en_rd_reg  <= en_bits_reg[idx_reg[SW-1:0]];
        end
    end

endmodule
`default_nettype wire

// ----- design/sound_command_queue_engine_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sound_command_queue_engine_core: sound command mailbox
// Command ring, driver state and effect slot table behind a start/busy port.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the item fields and raise start while busy is low; the item is
//   taken at that edge. mode selects enqueue, execute head command, slot
//   write or slot read.
//   Each item gives one result beat, shown with done high for one cycle,
//   after the capture, ring/slot read and execute steps. Except after a
//   driver reset, busy drops as done rises; the one-item sequencer takes
//   no new item until the previous item's beat is shown.
//   Driver status, master level, track and queue count hold their values
//   between beats.
//   After reset the slot memory is cleared one entry per cycle, which
//   keeps busy high until the sweep ends. A driver reset command clears
//   the enable bits at once and reruns that sweep, so busy stays high
//   after its beat until that sweep ends.
//   The receiver cannot stall; each result beat must be taken when shown.
// ----------------------------------------------------------------------------
module sound_command_queue_engine_core
    import scqe_pkg::*;
#(
    parameter int QUEUE_DEPTH       = 16,
    parameter int SLOT_COUNT        = 32,
    parameter int EFFECT_FIRST_SLOT = 16
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  mode,
    input  wire  [3:0]  cmd_code,
    input  wire  [15:0] track_id,
    input  wire  [7:0]  volume,
    input  wire  [7:0]  pan,
    input  wire  [5:0]  slot_index,
    input  wire         slot_enable,
    output logic        done,
    output logic        accepted,
    output logic [2:0]  driver_status,
    output logic [6:0]  master_level,
    output logic [15:0] current_track,
    output logic [4:0]  queue_count,
    output logic        slot_enabled,
    output logic [7:0]  slot_volume,
    output logic [7:0]  slot_pan
);

    scqe_ctl_t ctl;
    scqe_sts_t sts;

    scqe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl),
        .sts   (sts)
    );

    scqe_dp #(
        .QUEUE_DEPTH       (QUEUE_DEPTH),
        .SLOT_COUNT        (SLOT_COUNT),
        .EFFECT_FIRST_SLOT (EFFECT_FIRST_SLOT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .mode          (mode),
        .cmd_code      (cmd_code),
        .track_id      (track_id),
        .volume        (volume),
        .pan           (pan),
        .slot_index    (slot_index),
        .slot_enable   (slot_enable),
        .done          (done),
        .accepted      (accepted),
        .driver_status (driver_status),
        .master_level  (master_level),
        .current_track (current_track),
        .queue_count   (queue_count),
        .slot_enabled  (slot_enabled),
        .slot_volume   (slot_volume),
        .slot_pan      (slot_pan)
    );

endmodule
`default_nettype wire

// ----- design/scqe_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scqe_checker: port level checks
// Beat timing and result ranges seen at the top level ports.
// ----------------------------------------------------------------------------
module scqe_checker
    import scqe_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        done,
    input wire [2:0]  driver_status,
    input wire [4:0]  queue_count
);

    // a taken item makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");

    // result beat lasts one cycle
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");

    // a taken item is followed by a result beat
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done) else $error("result beat missing");

    // status stays within the four defined codes
    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        driver_status <= ST_PAUSED) else $error("bad driver status");

    // queue never exceeds its depth
    a_q: assert property (@(posedge clk) disable iff (!rst_n)
        queue_count <= 5'd16) else $error("queue count too high");

endmodule

bind sound_command_queue_engine_core scqe_checker u_scqe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .driver_status (driver_status),
    .queue_count   (queue_count)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: sound command mailbox testbench
// Drives enqueue, execute, slot write and slot read items through the
// start/busy port, predicts every result beat and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top
    import scqe_pkg::*;
;

    localparam int QDEPTH  = 16;
    localparam int NSLOTS  = 32;
    localparam int FX_BASE = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [3:0] CMD_UNKNOWN = 4'd15;

    // result beat as predicted
    typedef struct packed {
        logic        acc;
        logic [2:0]  status;
        logic [6:0]  master;
        logic [15:0] track;
        logic [4:0]  count;
        logic        s_en;
        logic [7:0]  s_vol;
        logic [7:0]  s_pan;
    } beat_t;

    typedef struct packed {
        logic [3:0]  ctype;
        logic [15:0] target;
        logic [7:0]  vol;
        logic [7:0]  pan;
    } queued_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [3:0]  cmd_code;
    logic [15:0] track_id;
    logic [7:0]  volume;
    logic [7:0]  pan;
    logic [5:0]  slot_index;
    logic        slot_enable;
    logic        done;
    logic        accepted;
    logic [2:0]  driver_status;
    logic [6:0]  master_level;
    logic [15:0] current_track;
    logic [4:0]  queue_count;
    logic        slot_enabled;
    logic [7:0]  slot_volume;
    logic [7:0]  slot_pan;

    // predictor state
    queued_cmd_t cmd_ring [QDEPTH];
    int          rd_ptr, wr_ptr, pending_cmds;
    logic [6:0]  master_q;
    logic [15:0] track_q;
    logic [2:0]  status_q;
    logic        slot_en_q  [NSLOTS];
    logic [7:0]  slot_vol_q [NSLOTS];
    logic [7:0]  slot_pan_q [NSLOTS];

    beat_t expected_beats[$];
    int    fail_count;
    int    beats_seen;
    int    idle_cycles;
    int    send_idle_pct;

    sound_command_queue_engine_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .cmd_code(cmd_code), .track_id(track_id),
        .volume(volume), .pan(pan), .slot_index(slot_index),
        .slot_enable(slot_enable), .done(done), .accepted(accepted),
        .driver_status(driver_status), .master_level(master_level),
        .current_track(current_track), .queue_count(queue_count),
        .slot_enabled(slot_enabled), .slot_volume(slot_volume),
        .slot_pan(slot_pan)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] cap127(input logic [7:0] v);
        return (v > 8'd127) ? 8'd127 : v;
    endfunction

    function automatic void clear_mailbox();
        for (int i = 0; i < NSLOTS; i++)
        begin
            slot_en_q[i]  = 1'b0;
            slot_vol_q[i] = 8'd0;
            slot_pan_q[i] = 8'd0;
        end
        rd_ptr = 0;
        wr_ptr = 0;
        pending_cmds = 0;
        master_q = VOL_CAP;
        track_q = 16'd0;
        status_q = ST_READY;
    endfunction

    // apply one dequeued command to the driver state
    function automatic void run_command(input queued_cmd_t c);
        bit placed;
        placed = 1'b0;
        case (c.ctype)
            CMD_PLAY:
            begin
                track_q = c.target;
                status_q = ST_PLAYING;
            end
            CMD_STOP:
            begin
                track_q = 16'd0;
                status_q = ST_STOPPED;
            end
            CMD_PAUSE: status_q = ST_PAUSED;
            CMD_RESUME: if (track_q != 16'd0) status_q = ST_PLAYING;
            CMD_MASTER: master_q = 7'(cap127(c.vol));
            CMD_SFXPLAY:
                for (int i = FX_BASE; i < NSLOTS; i++)
                    if (!placed && !slot_en_q[i])
                    begin
                        slot_en_q[i] = 1'b1;
                        slot_vol_q[i] = cap127(c.vol);
                        slot_pan_q[i] = c.pan;
                        placed = 1'b1;
                    end
            CMD_SFXSTOP:
                for (int i = FX_BASE; i < NSLOTS; i++)
                    slot_en_q[i] = 1'b0;
            CMD_RESET: clear_mailbox();
            default: ;
        endcase
    endfunction

    // mailbox predictor: one result per item
    function automatic beat_t predict_mailbox(input logic [1:0] m, input logic [3:0] ct,
        input logic [15:0] tg, input logic [7:0] v, input logic [7:0] p,
        input logic [5:0] idx, input logic en);
        beat_t r;
        r = '0;
        case (m)
            MODE_ENQ:
                if (pending_cmds < QDEPTH)
                begin
                    cmd_ring[wr_ptr] = '{ctype: ct, target: tg, vol: v, pan: p};
                    wr_ptr = (wr_ptr + 1) % QDEPTH;
                    pending_cmds++;
                    r.acc = 1'b1;
                end
            MODE_EXEC:
                if (pending_cmds != 0)
                begin
                    queued_cmd_t c;
                    c = cmd_ring[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % QDEPTH;
                    pending_cmds--;
                    run_command(c);
                    r.acc = 1'b1;
                end
            MODE_WRITE:
                if (idx < NSLOTS)
                begin
                    slot_en_q[idx] = en;
                    slot_vol_q[idx] = v;
                    slot_pan_q[idx] = p;
                end
            default:
                if (idx < NSLOTS)
                begin
                    r.s_en = slot_en_q[idx];
                    r.s_vol = slot_vol_q[idx];
                    r.s_pan = slot_pan_q[idx];
                end
        endcase
        r.status = status_q;
        r.master = master_q;
        r.track = track_q;
        r.count = pending_cmds[4:0];
        return r;
    endfunction

    // send one item; predict it once busy drops after the accepting edge
    task automatic send_item(input logic [1:0] m, input logic [3:0] ct,
        input logic [15:0] tg, input logic [7:0] v, input logic [7:0] p,
        input logic [5:0] idx, input logic en);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        cmd_code <= ct;
        track_id <= tg;
        volume <= v;
        pan <= p;
        slot_index <= idx;
        slot_enable <= en;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_beats.push_back(predict_mailbox(m, ct, tg, v, p, idx, en));
    endtask

    task automatic send_random_item(input int well_formed);
        logic [1:0] m;
        logic [3:0] ct;
        m = 2'($urandom_range(3));
        // keep well-formed opcodes in the defined range and bias them toward effect play
        ct = (well_formed != 0) ? 4'($urandom_range(10)) : 4'($urandom);
        if (well_formed != 0 && $urandom_range(9) < 3)
            ct = CMD_SFXPLAY;
        send_item(m, ct, 16'($urandom), 8'($urandom), 8'($urandom),
            (well_formed != 0) ? 6'($urandom_range(NSLOTS - 1)) : 6'($urandom),
            1'($urandom));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            beat_t e;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                e = expected_beats.pop_front();
                beats_seen++;
                if (accepted !== e.acc)
                begin
                    $error("accepted exp %0d got %0d", e.acc, accepted); fail_count++;
                end
                if (driver_status !== e.status)
                begin
                    $error("driver_status exp %0d got %0d", e.status, driver_status);
                    fail_count++;
                end
                if (master_level !== e.master)
                begin
                    $error("master_level exp %0d got %0d", e.master, master_level);
                    fail_count++;
                end
                if (current_track !== e.track)
                begin
                    $error("current_track exp %0d got %0d", e.track, current_track);
                    fail_count++;
                end
                if (queue_count !== e.count)
                begin
                    $error("queue_count exp %0d got %0d", e.count, queue_count);
                    fail_count++;
                end
                if (slot_enabled !== e.s_en)
                begin
                    $error("slot_enabled exp %0d got %0d", e.s_en, slot_enabled);
                    fail_count++;
                end
                if (slot_volume !== e.s_vol)
                begin
                    $error("slot_volume exp %0d got %0d", e.s_vol, slot_volume);
                    fail_count++;
                end
                if (slot_pan !== e.s_pan)
                begin
                    $error("slot_pan exp %0d got %0d", e.s_pan, slot_pan);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles with no taken item and no result beat
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // queue limits: fill past full, drain past empty
    task automatic test_queue_bounds();
        for (int i = 0; i < QDEPTH + 1; i++)
            send_item(MODE_ENQ, (i == 0) ? CMD_PLAY : CMD_UNKNOWN, 16'hFFFF, 8'hFF, 8'h00,
                6'd0, 1'b0);
        for (int i = 0; i < QDEPTH + 1; i++)
            send_item(MODE_EXEC, CMD_NONE, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
    endtask

    // every defined command code but CMD_NONE, effect slot fill and reset
    task automatic test_commands();
        send_item(MODE_ENQ, CMD_RESUME, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_ENQ, CMD_MASTER, 16'd0, 8'd200, 8'd0, 6'd0, 1'b0);
        send_item(MODE_ENQ, CMD_SFXPLAY, 16'd0, 8'd255, 8'hAA, 6'd0, 1'b0);
        send_item(MODE_ENQ, CMD_PAUSE, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_ENQ, CMD_RESUME, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_ENQ, CMD_TRKVOL, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_ENQ, CMD_FADE, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_ENQ, CMD_STOP, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        for (int i = 0; i < 8; i++)
            send_item(MODE_EXEC, CMD_NONE, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_READ, CMD_NONE, 16'd0, 8'd0, 8'd0, 6'(FX_BASE), 1'b0);
        // fill every effect slot, then play more with no room left
        for (int i = 0; i < NSLOTS - FX_BASE + 1; i++)
        begin
            send_item(MODE_ENQ, CMD_SFXPLAY, 16'd0, 8'($urandom), 8'($urandom), 6'd0, 1'b0);
            send_item(MODE_EXEC, CMD_NONE, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        end
        send_item(MODE_READ, CMD_NONE, 16'd0, 8'd0, 8'd0, 6'(NSLOTS - 1), 1'b0);
        send_item(MODE_ENQ, CMD_SFXSTOP, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_EXEC, CMD_NONE, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_ENQ, CMD_RESET, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_ENQ, CMD_PLAY, 16'd1, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_EXEC, CMD_NONE, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
    endtask

    // slot writes and reads, including out-of-range indexes
    task automatic test_slot_access();
        send_item(MODE_WRITE, CMD_NONE, 16'd0, 8'hFF, 8'hFF, 6'd0, 1'b1);
        send_item(MODE_WRITE, CMD_NONE, 16'd0, 8'h55, 8'hAA, 6'(NSLOTS - 1), 1'b1);
        send_item(MODE_WRITE, CMD_NONE, 16'd0, 8'h12, 8'h34, 6'd63, 1'b1);
        send_item(MODE_READ, CMD_NONE, 16'd0, 8'd0, 8'd0, 6'd0, 1'b0);
        send_item(MODE_READ, CMD_NONE, 16'd0, 8'd0, 8'd0, 6'(NSLOTS - 1), 1'b0);
        send_item(MODE_READ, CMD_NONE, 16'd0, 8'd0, 8'd0, 6'd63, 1'b0);
    endtask

    // random traffic in three idling phases
    task automatic test_random_traffic();
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 79 : 0;
            for (int i = 0; i < 185; i++)
                send_random_item(($urandom_range(9) < 8) ? 1 : 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_ENQ;
        cmd_code = CMD_NONE;
        track_id = 16'd0;
        volume = 8'd0;
        pan = 8'd0;
        slot_index = 6'd0;
        slot_enable = 1'b0;
        fail_count = 0;
        beats_seen = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        clear_mailbox();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_queue_bounds();
        test_commands();
        test_slot_access();
        test_random_traffic();
        wait_drained();

        $display("Covered queue full/empty, all command codes, effect slot fill,");
        $display("slot access in and out of range; %0d result beats checked.", beats_seen);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
